// ===== sv/shpj_pkg.sv =====
// ============================================================================
// shpj_pkg
// Shared types and constants for the drive health page judge.
// ============================================================================
package shpj_pkg;

    // One byte of the health page.
    typedef struct packed {
        logic [7:0] page_byte;
        logic       page_end;
    } shpj_in_t;

    // Verdict plus the captured counters for one page.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [47:0] reallocated_count;
        logic [47:0] pending_count;
        logic [47:0] uncorrectable_count;
        logic [47:0] hours_powered;
        logic [48:0] bad_sector_total;
    } shpj_out_t;

    localparam logic [1:0] VERDICT_GOOD    = 2'd0;
    localparam logic [1:0] VERDICT_WORN    = 2'd1;
    localparam logic [1:0] VERDICT_FAILING = 2'd2;

    localparam logic FMT_ATA  = 1'b0;
    localparam logic FMT_NVME = 1'b1;

    // Capture slots
    localparam int CAP_NUM     = 4;
    localparam int IX_REALLOC  = 0;
    localparam int IX_PENDING  = 1;
    localparam int IX_UNCORR   = 2;
    localparam int IX_HOURS    = 3;

    // Attribute id owning each capture slot, in slot order
    localparam logic [7:0] ATTR_ID [CAP_NUM] = '{8'd5, 8'd197, 8'd198, 8'd9};

    // Layout of one attribute slot
    localparam logic [3:0] SLOT_LEN_M1  = 4'd11;
    localparam logic [3:0] RAW_FIRST    = 4'd5;
    localparam logic [3:0] RAW_LAST     = 4'd10;
    localparam logic [9:0] SLOTS_START  = 10'd2;

    // NVMe health log layout
    localparam logic [9:0] NVME_FLAG_AT  = 10'd0;
    localparam logic [9:0] NVME_HOURS_AT = 10'd128;
    localparam logic [9:0] NVME_MEDIA_AT = 10'd160;
    localparam logic [9:0] NVME_FIELD_LEN = 10'd6;
    localparam int         NVME_PEND_BIT = 2;

    localparam logic [9:0] OFS_MAX = 10'd1023;

endpackage

// ===== sv/shpj_parser.sv =====
// ============================================================================
// shpj_parser
// Page walk state, per-byte capture logic and verdict forming.
// ============================================================================
module shpj_parser #(
    parameter int ATTR_SLOTS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  shpj_pkg::shpj_in_t  item,
    input  logic                page_format,
    output shpj_pkg::shpj_out_t result
);
    import shpj_pkg::*;

    localparam int SLOT_W = $clog2(ATTR_SLOTS + 1);

    logic [9:0]        offset_reg,   offset_next;
    logic [3:0]        pos_reg,      pos_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [7:0]        id_reg,       id_next;
    logic [47:0]       gather_reg,   gather_next;
    logic [47:0]       cap_reg  [CAP_NUM];
    logic [47:0]       cap_next [CAP_NUM];
    logic [CAP_NUM-1:0] flag_reg,    flag_next;

    logic        walk;
    logic        ata;
    logic [3:0]  raw_lane;
    logic [9:0]  hours_rel;
    logic [9:0]  media_rel;
    logic [47:0] byte_wide;
    logic [48:0] bad_sum;

    always_comb
    begin
        walk      = (offset_reg >= SLOTS_START) && (slot_reg < SLOT_W'(ATTR_SLOTS));
        ata       = (page_format == FMT_ATA);
        raw_lane  = pos_reg - RAW_FIRST;
        hours_rel = offset_reg - NVME_HOURS_AT;
        media_rel = offset_reg - NVME_MEDIA_AT;
        byte_wide = 48'(item.page_byte);

        offset_next = offset_reg;
        pos_next    = pos_reg;
        slot_next   = slot_reg;
        id_next     = id_reg;
        gather_next = gather_reg;
        flag_next   = flag_reg;
        for (int k = 0; k < CAP_NUM; k++)
        begin
            cap_next[k] = cap_reg[k];
        end

        // attribute slot walk, counters move in both formats
        if (walk)
        begin
            if (ata)
            begin
                if (pos_reg == 4'd0)
                begin
                    id_next = item.page_byte;
                end
                else if (pos_reg >= RAW_FIRST && pos_reg <= RAW_LAST)
                begin
                    gather_next = ((pos_reg == RAW_FIRST) ? 48'd0 : gather_reg)
                                | (byte_wide << {raw_lane[2:0], 3'b000});
                    if (pos_reg == RAW_LAST)
                    begin
                        // first matching slot wins
                        for (int k = 0; k < CAP_NUM; k++)
                        begin
                            if (id_reg == ATTR_ID[k] && !flag_reg[k])
                            begin
                                cap_next[k]  = gather_next;
                                flag_next[k] = 1'b1;
                            end
                        end
                    end
                end
            end
            if (pos_reg == SLOT_LEN_M1)
            begin
                pos_next  = 4'd0;
                slot_next = slot_reg + SLOT_W'(1);
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end

        // NVMe log fields
        if (!ata)
        begin
            if (offset_reg == NVME_FLAG_AT)
            begin
                cap_next[IX_PENDING] = {47'd0, item.page_byte[NVME_PEND_BIT]};
            end
            else if (offset_reg >= NVME_HOURS_AT &&
                     offset_reg < NVME_HOURS_AT + NVME_FIELD_LEN)
            begin
                cap_next[IX_HOURS] = cap_reg[IX_HOURS]
                                   | (byte_wide << {hours_rel[2:0], 3'b000});
            end
            else if (offset_reg >= NVME_MEDIA_AT &&
                     offset_reg < NVME_MEDIA_AT + NVME_FIELD_LEN)
            begin
                cap_next[IX_UNCORR] = cap_reg[IX_UNCORR]
                                    | (byte_wide << {media_rel[2:0], 3'b000});
            end
        end

        if (offset_reg != OFS_MAX)
        begin
            offset_next = offset_reg + 10'd1;
        end

        // result is formed from the values after this byte
        bad_sum = {1'b0, cap_next[IX_PENDING]} + {1'b0, cap_next[IX_UNCORR]};
        result.reallocated_count   = cap_next[IX_REALLOC];
        result.pending_count       = cap_next[IX_PENDING];
        result.uncorrectable_count = cap_next[IX_UNCORR];
        result.hours_powered       = cap_next[IX_HOURS];
        result.bad_sector_total    = bad_sum;
        if (cap_next[IX_PENDING] != 48'd0 || cap_next[IX_UNCORR] != 48'd0)
        begin
            result.verdict = VERDICT_FAILING;
        end
        else if (cap_next[IX_REALLOC] != 48'd0)
        begin
            result.verdict = VERDICT_WORN;
        end
        else
        begin
            result.verdict = VERDICT_GOOD;
        end

        // fresh page after the last byte
        if (item.page_end)
        begin
            offset_next = 10'd0;
            pos_next    = 4'd0;
            slot_next   = '0;
            id_next     = 8'd0;
            gather_next = 48'd0;
            flag_next   = '0;
            for (int k = 0; k < CAP_NUM; k++)
            begin
                cap_next[k] = 48'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 10'd0;
            pos_reg    <= 4'd0;
            slot_reg   <= '0;
            id_reg     <= 8'd0;
            gather_reg <= 48'd0;
            flag_reg   <= '0;
            for (int k = 0; k < CAP_NUM; k++)
            begin
                cap_reg[k] <= 48'd0;
            end
        end
        else if (step_en)
        begin
            offset_reg <= offset_next;
            pos_reg    <= pos_next;
            slot_reg   <= slot_next;
            id_reg     <= id_next;
            gather_reg <= gather_next;
            flag_reg   <= flag_next;
            for (int k = 0; k < CAP_NUM; k++)
            begin
                cap_reg[k] <= cap_next[k];
            end
        end
    end

endmodule

// ===== sv/shpj_out_reg.sv =====
// ============================================================================
// shpj_out_reg
// Result register holding one verdict item until the receiver takes it.
// ============================================================================
module shpj_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  shpj_pkg::shpj_out_t load_data,
    input  logic                out_ready,
    output logic                out_valid,
    output shpj_pkg::shpj_out_t out_data,
    output logic                free
);
    import shpj_pkg::*;

    logic      valid_reg, valid_next;
    shpj_out_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/smart_health_page_judge_core.sv =====
// ============================================================================
// smart_health_page_judge_core
// Drive health page judge: parses ATA SMART or NVMe health pages.
// ============================================================================
// Usage:
//   Page bytes enter on in_valid/in_ready/in_data, one item per byte in
//   offset order; in_data.page_end marks the last byte of a page. One
//   verdict item leaves on out_valid/out_ready/out_data per page end.
//   cfg_we/cfg_data set the page format (0 ATA SMART, 1 NVMe log); write
//   it only between pages with the block drained.
// Timing:
//   Two register stages: an input register, then the parse/verdict logic,
//   then the result register. The verdict enters the result register,
//   raising out_valid, as the staged page_end byte moves on. One byte
//   per cycle sustained; the single result register is the only limit.
// Stall:
//   While a verdict waits untaken, bytes that end no page still flow in;
//   the next page_end byte waits in the input register, and in_ready drops
//   until the result register frees up.
// Reset:
//   rst_n clears the format to ATA, all walk counters and captures, and
//   both valid flags. No clearing pass is needed.
// ============================================================================
module smart_health_page_judge_core #(
    parameter int ATTR_SLOTS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  shpj_pkg::shpj_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output shpj_pkg::shpj_out_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_data
);
    import shpj_pkg::*;

    logic      format_reg;
    logic      stage_valid_reg, stage_valid_next;
    shpj_in_t  stage_item_reg;
    logic      out_free;
    logic      advance;
    logic      take;
    shpj_out_t result;

    // the staged byte moves on unless it ends a page and the result is held
    assign advance  = stage_valid_reg && (!stage_item_reg.page_end || out_free);
    assign in_ready = !stage_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            format_reg      <= FMT_ATA;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_we)
            begin
                format_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= in_data;
        end
    end

    shpj_parser #(
        .ATTR_SLOTS (ATTR_SLOTS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (stage_item_reg),
        .page_format (format_reg),
        .result      (result)
    );

    shpj_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && stage_item_reg.page_end),
        .load_data (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .free      (out_free)
    );

endmodule

// ===== sv/shpj_checker.sv =====
// ============================================================================
// shpj_checker
// Port-level checks on the health page judge.
// ============================================================================
module shpj_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input shpj_pkg::shpj_out_t out_data
);
    import shpj_pkg::*;

    // held verdict stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("verdict item changed while stalled");

    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bad_sector_total ==
            ({1'b0, out_data.pending_count} + {1'b0, out_data.uncorrectable_count}))
        else $error("bad sector total mismatch");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.verdict ==
            ((out_data.pending_count != 48'd0 || out_data.uncorrectable_count != 48'd0)
                ? VERDICT_FAILING
                : ((out_data.reallocated_count != 48'd0) ? VERDICT_WORN : VERDICT_GOOD)))
        else $error("verdict does not follow counters");

    // with no result pending the input side can never stall
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind smart_health_page_judge_core shpj_checker u_shpj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/tb_smart_health_page_judge_core.sv =====
// ============================================================================
// tb_smart_health_page_judge_core
// Self-checking bench for the drive health page judge.
// Pages go in one byte per item and are checked against a cycle-free model
// of the slot walk and NVMe field capture. Directed pages cover extremes,
// repeated ids, the slot limit, offset saturation and a mid-page format
// switch. Random pages of mixed length, kind and format follow, with
// back-pressure and idle gaps.
// ============================================================================
module tb_smart_health_page_judge_core;

    import shpj_pkg::*;

    localparam int N_SLOTS        = 30;
    localparam int SLOT_BYTES     = 12;
    localparam int RAW_BYTES      = 6;
    localparam int DIR_ROWS       = 15;
    localparam int RAND_ITEMS     = 400;
    localparam int CALM_PHASE     = 3;
    localparam int HOLD_PHASE     = 5;
    localparam int SETTLE_CYCLES  = 4;    // two register stages plus margin
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {KIND_ATA, KIND_NVME, KIND_NOISE} page_kind_e;

    // n bytes of val, little-endian, starting at page offset at
    typedef struct packed {
        logic [10:0] at;
        logic [2:0]  n;
        logic [47:0] val;
    } poke_t;

    // One directed page: format, length, filler byte, up to four pokes,
    // optional in-page format flip, and optionally a hand-written verdict.
    typedef struct packed {
        logic        fmt;
        logic [10:0] len;
        logic [7:0]  fill;
        logic [10:0] flip_at;
        poke_t [3:0] pk;
        logic        typed;
        shpj_out_t   want;
    } dir_row_t;

    localparam poke_t NO_POKE = '0;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    shpj_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    shpj_out_t out_data;
    logic      cfg_we;
    logic      cfg_data;

    smart_health_page_judge_core #(
        .ATTR_SLOTS (N_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Page walk model: format, offsets, slot walk and captures
    // ------------------------------------------------------------------------
    logic               fmt;
    logic [9:0]         ofs;
    logic [3:0]         slot_pos;
    logic [4:0]         slot_num;
    logic [7:0]         id_latch;
    logic [47:0]        gather;
    logic [47:0]        cap [CAP_NUM];
    logic [CAP_NUM-1:0] cap_flags;

    shpj_out_t due_verdicts [$];   // verdicts owed by the DUT, oldest first
    logic [7:0] page_q [$];        // bytes of the page being sent
    dir_row_t   dir_tab [DIR_ROWS];

    bit calm;       // no idling on either side
    bit hold_req;   // ask the receiver for one long hold-off
    int fails = 0;
    int bytes_sent;
    int pages_sent;
    int verdicts_checked = 0;
    int cfg_writes;
    int quiet = 0;
    shpj_out_t got;
    shpj_out_t owed;

    function automatic void clear_walk();
        int k;
        ofs       = '0;
        slot_pos  = '0;
        slot_num  = '0;
        id_latch  = '0;
        gather    = '0;
        cap_flags = '0;
        for (k = 0; k < CAP_NUM; k++)
            cap[k] = '0;
    endfunction

    // Advance the model by one accepted byte; returns 1 with the verdict
    // when the byte ends the page.
    function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                      output shpj_out_t v);
        int hit;
        int k;
        v = '0;
        // Slot counters run in both formats; only ATA latches anything.
        if (ofs >= SLOTS_START && slot_num < N_SLOTS) begin
            if (fmt == FMT_ATA) begin
                if (slot_pos == 4'd0)
                    id_latch = b;
                else if (slot_pos >= RAW_FIRST && slot_pos <= RAW_LAST) begin
                    if (slot_pos == RAW_FIRST)
                        gather = '0;
                    gather = gather | ({40'd0, b} << (8 * (slot_pos - RAW_FIRST)));
                    if (slot_pos == RAW_LAST) begin
                        hit = -1;
                        for (k = CAP_NUM - 1; k >= 0; k--)
                            if (id_latch == ATTR_ID[k])
                                hit = k;
                        // first slot with a given id wins
                        if (hit >= 0 && !cap_flags[hit]) begin
                            cap[hit]       = gather;
                            cap_flags[hit] = 1'b1;
                        end
                    end
                end
            end
            if (slot_pos == SLOT_LEN_M1) begin
                slot_pos = '0;
                slot_num = slot_num + 5'd1;
            end
            else
                slot_pos = slot_pos + 4'd1;
        end
        if (fmt == FMT_NVME) begin
            if (ofs == NVME_FLAG_AT)
                cap[IX_PENDING] = {47'd0, b[NVME_PEND_BIT]};
            else if (ofs >= NVME_HOURS_AT && ofs < NVME_HOURS_AT + NVME_FIELD_LEN)
                cap[IX_HOURS] = cap[IX_HOURS]
                              | ({40'd0, b} << (8 * (ofs - NVME_HOURS_AT)));
            else if (ofs >= NVME_MEDIA_AT && ofs < NVME_MEDIA_AT + NVME_FIELD_LEN)
                cap[IX_UNCORR] = cap[IX_UNCORR]
                               | ({40'd0, b} << (8 * (ofs - NVME_MEDIA_AT)));
        end
        if (ofs != OFS_MAX)
            ofs = ofs + 10'd1;
        if (!last)
            return 1'b0;

        if (cap[IX_PENDING] != '0 || cap[IX_UNCORR] != '0)
            v.verdict = VERDICT_FAILING;
        else if (cap[IX_REALLOC] != '0)
            v.verdict = VERDICT_WORN;
        else
            v.verdict = VERDICT_GOOD;
        v.reallocated_count   = cap[IX_REALLOC];
        v.pending_count       = cap[IX_PENDING];
        v.uncorrectable_count = cap[IX_UNCORR];
        v.hours_powered       = cap[IX_HOURS];
        v.bad_sector_total    = {1'b0, cap[IX_PENDING]} + {1'b0, cap[IX_UNCORR]};
        clear_walk();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------------
    function automatic poke_t pk(input int at, input int n, input logic [47:0] val);
        poke_t p;
        p.at  = at[10:0];
        p.n   = n[2:0];
        p.val = val;
        return p;
    endfunction

    function automatic shpj_out_t res(input logic [1:0] v, input logic [47:0] re,
                                      input logic [47:0] pe, input logic [47:0] un,
                                      input logic [47:0] hr, input logic [48:0] tot);
        shpj_out_t r;
        r.verdict             = v;
        r.reallocated_count   = re;
        r.pending_count       = pe;
        r.uncorrectable_count = un;
        r.hours_powered       = hr;
        r.bad_sector_total    = tot;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic f, input int len, input logic [7:0] fill,
                                        input int flip_at, input poke_t p0, input poke_t p1,
                                        input poke_t p2, input poke_t p3, input logic typed,
                                        input shpj_out_t want);
        dir_row_t d;
        d.fmt     = f;
        d.len     = len[10:0];
        d.fill    = fill;
        d.flip_at = flip_at[10:0];
        d.pk[0]   = p0;
        d.pk[1]   = p1;
        d.pk[2]   = p2;
        d.pk[3]   = p3;
        d.typed   = typed;
        d.want    = want;
        return d;
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return ATTR_ID[IX_REALLOC];
            1:       return ATTR_ID[IX_PENDING];
            2:       return ATTR_ID[IX_UNCORR];
            3:       return ATTR_ID[IX_HOURS];
            4:       return 8'h00;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [47:0] pick_raw();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3:       return MAX48;
            4:       return 48'd1;
            5:       return $urandom_range(1, 255);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly short pages; long ones are slow, so only a few
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(1, 24);
        else
            return $urandom_range(25, 170);
    endfunction

    // Drop n bytes of val little-endian into the page, clipped to its length
    task automatic put_le(input int at, input int n, input logic [47:0] val);
        int k;
        for (k = 0; k < n; k++)
            if (at + k < page_q.size())
                page_q[at + k] = val[8 * k +: 8];
    endtask

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Format writes only with nothing in flight: wait out owed verdicts,
    // then the pipeline depth, then one write cycle.
    task automatic set_format(input logic f);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
        fmt = f;
        cfg_writes++;
    endtask

    // One byte item: optional idle gap, then hold valid until taken
    task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                            input shpj_out_t want);
        int        gap;
        shpj_out_t v;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 30)
            gap++;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.page_byte <= b;
        in_data.page_end  <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        if (judge_byte(b, last, v))
            due_verdicts.push_back(typed ? want : v);
    endtask

    // Send page_q; flip_at != 0 toggles the format before that byte
    task automatic send_page(input int flip_at, input logic typed, input shpj_out_t want);
        int i;
        for (i = 0; i < page_q.size(); i++) begin
            if (flip_at != 0 && i == flip_at)
                set_format(~fmt);
            put_byte(page_q[i], i == page_q.size() - 1, typed, want);
        end
        pages_sent++;
    endtask

    // Random page: mostly well-formed for the current format, with random
    // content; some of the other layout and some pure noise.
    task automatic random_page(input int len);
        page_kind_e  kind;
        int          r;
        int          s;
        int          base;
        int          flip_at;
        bit          healthy;
        logic [7:0]  id;
        logic [47:0] raw;
        r = $urandom_range(0, 9);
        if (r == 0)
            kind = KIND_NOISE;
        else if (r == 1)
            kind = (fmt == FMT_ATA) ? KIND_NVME : KIND_ATA;
        else
            kind = (fmt == FMT_ATA) ? KIND_ATA : KIND_NVME;
        // healthy pages keep pending/uncorrectable at zero so good and
        // worn verdicts show up too
        healthy = ($urandom_range(0, 9) < 4);
        page_q.delete();
        repeat (len) begin
            id = $urandom_range(0, 255);
            page_q.push_back(id);
        end
        if (kind == KIND_ATA) begin
            for (s = 0; s < N_SLOTS + 2; s++) begin
                base = SLOTS_START + s * SLOT_BYTES;
                id   = pick_id();
                raw  = pick_raw();
                if (healthy && (id == ATTR_ID[IX_PENDING] || id == ATTR_ID[IX_UNCORR]))
                    raw = '0;
                if (base < len)
                    page_q[base] = id;
                put_le(base + RAW_FIRST, RAW_BYTES, raw);
            end
        end
        else if (kind == KIND_NVME) begin
            id                = page_q[0];
            id[NVME_PEND_BIT] = !healthy && ($urandom_range(0, 1) != 0);
            page_q[0]         = id;
            put_le(NVME_HOURS_AT, RAW_BYTES, pick_raw());
            put_le(NVME_MEDIA_AT, RAW_BYTES, healthy ? 48'd0 : pick_raw());
        end
        flip_at = (len >= 4 && $urandom_range(0, 99) < 8) ? $urandom_range(1, len - 1) : 0;
        send_page(flip_at, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm stretches, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every taken verdict item against the oldest one owed
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [48:0] want,
                               input logic [48:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got = out_data;
            if (due_verdicts.size() == 0) begin
                $error("verdict item with none owed");
                fails++;
            end
            else begin
                owed = due_verdicts.pop_front();
                check_field("verdict", owed.verdict, got.verdict);
                check_field("reallocated_count", owed.reallocated_count,
                            got.reallocated_count);
                check_field("pending_count", owed.pending_count, got.pending_count);
                check_field("uncorrectable_count", owed.uncorrectable_count,
                            got.uncorrectable_count);
                check_field("hours_powered", owed.hours_powered, got.hours_powered);
                check_field("bad_sector_total", owed.bad_sector_total,
                            got.bad_sector_total);
                verdicts_checked++;
            end
        end
    end

    // Watchdog: too long without any item taken on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT) begin
            $display("smart_health_page_judge_core test failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int       r;
        int       k;
        int       phase;
        int       bytes_from;
        dir_row_t row;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_data  = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        bytes_sent       = 0;
        pages_sent       = 0;
        cfg_writes       = 0;
        fmt = FMT_ATA;
        clear_walk();

        // Directed pages. ATA slot s: id at 2+12s, raw at 7+12s.
        dir_tab[0]  = mk_row(FMT_ATA, 1, 8'h00, 0, NO_POKE, NO_POKE, NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, 0, 0));
        // reallocated at full scale
        dir_tab[1]  = mk_row(FMT_ATA, 14, 8'h00, 0, pk(2, 1, 5), pk(7, 6, MAX48),
                             NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_WORN, MAX48, 0, 0, 0, 0));
        // pending 1 plus uncorrectable max: sum carries into bit 48
        dir_tab[2]  = mk_row(FMT_ATA, 26, 8'h00, 0, pk(2, 1, 197), pk(7, 6, 1),
                             pk(14, 1, 198), pk(19, 6, MAX48),
                             1'b1, res(VERDICT_FAILING, 0, 1, MAX48, 0,
                                       49'h1_0000_0000_0000));
        // repeated id: only the first slot counts
        dir_tab[3]  = mk_row(FMT_ATA, 26, 8'h00, 0, pk(2, 1, 9), pk(7, 6, MAX48),
                             pk(14, 1, 9), pk(19, 6, 7),
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, MAX48, 0));
        // largest possible bad sector total
        dir_tab[4]  = mk_row(FMT_ATA, 26, 8'h00, 0, pk(2, 1, 197), pk(7, 6, MAX48),
                             pk(14, 1, 198), pk(19, 6, MAX48),
                             1'b1, res(VERDICT_FAILING, 0, MAX48, MAX48, 0,
                                       49'h1_FFFF_FFFF_FFFE));
        // page ends inside the raw field: nothing captured
        dir_tab[5]  = mk_row(FMT_ATA, 10, 8'h00, 0, pk(2, 1, 5), pk(7, 6, MAX48),
                             NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, 0, 0));
        // all-ones bytes: id 255 matches nothing
        dir_tab[6]  = mk_row(FMT_ATA, 26, 8'hFF, 0, NO_POKE, NO_POKE, NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, 0, 0));
        // last slot counts, the one past it is ignored; the page runs on
        // past the offset limit
        dir_tab[7]  = mk_row(FMT_ATA, 1030, 8'h00, 0, pk(350, 1, 5), pk(355, 6, 3),
                             pk(362, 1, 198), pk(367, 6, 9), 1'b0, '0);
        // NVMe: pending flag alone on a one-byte page
        dir_tab[8]  = mk_row(FMT_NVME, 1, 8'h04, 0, NO_POKE, NO_POKE, NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_FAILING, 0, 1, 0, 0, 1));
        // NVMe: every flag bit but the pending one, media errors max
        dir_tab[9]  = mk_row(FMT_NVME, 166, 8'h00, 0, pk(0, 1, 8'hFB), pk(160, 6, MAX48),
                             NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_FAILING, 0, 0, MAX48, 0, {1'b0, MAX48}));
        dir_tab[10] = mk_row(FMT_NVME, 1, 8'hFF, 0, NO_POKE, NO_POKE, NO_POKE, NO_POKE,
                             1'b0, '0);
        // ends two bytes into the hours field
        dir_tab[11] = mk_row(FMT_NVME, 130, 8'h5A, 0, pk(0, 1, 0), NO_POKE, NO_POKE,
                             NO_POKE, 1'b0, '0);
        // id 5 everywhere is ignored in NVMe
        dir_tab[12] = mk_row(FMT_NVME, 134, 8'h05, 0, pk(0, 1, 0),
                             pk(128, 6, 48'h1234_5678_9ABC), NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, 48'h1234_5678_9ABC, 0));
        // format switch partway through the page
        dir_tab[13] = mk_row(FMT_ATA, 166, 8'h00, 100, pk(2, 1, 9), pk(7, 6, 8'h55),
                             pk(160, 6, 2), NO_POKE, 1'b0, '0);
        // everything cleared after the previous page
        dir_tab[14] = mk_row(FMT_ATA, 1, 8'h00, 0, NO_POKE, NO_POKE, NO_POKE, NO_POKE,
                             1'b1, res(VERDICT_GOOD, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_format(FMT_ATA);

        for (r = 0; r < DIR_ROWS; r++) begin
            row = dir_tab[r];
            if (row.fmt != fmt)
                set_format(row.fmt);
            page_q.delete();
            repeat (row.len) page_q.push_back(row.fill);
            for (k = 0; k < 4; k++)
                put_le(row.pk[k].at, row.pk[k].n, row.pk[k].val);
            send_page(row.flip_at, row.typed, row.want);
        end

        // Random phases. Each starts with a drained format write; one is
        // gap-free, one runs under a long receiver hold-off with short
        // pages so the input backs up.
        bytes_from = bytes_sent;
        phase      = 0;
        while (bytes_sent - bytes_from < RAND_ITEMS || phase <= HOLD_PHASE)
        begin
            set_format((phase % 3 == 2) ? ($urandom_range(0, 1) != 0) : phase[0]);
            calm = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE) begin
                hold_req = 1'b1;
                repeat (12) random_page($urandom_range(1, 8));
            end
            else
                repeat (calm ? 8 : 3) random_page(pick_len());
            phase++;
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d pages (ATA and NVMe, %0d format writes);",
                 bytes_sent, pages_sent, cfg_writes);
        $display("checked %0d verdicts, %0d field mismatches.", verdicts_checked, fails);
        if (fails == 0)
            $display("smart_health_page_judge_core test passed");
        else
            $display("smart_health_page_judge_core test failed");
        $finish;
    end

endmodule
